// File: design/ibdk_pkg.sv
// Package: widths, constants and the shared item type of the delta kernel block.
package ibdk_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS   = 16;
  localparam int SPACING_FRAC_BITS = 16;
  localparam int KFRAC             = 24;
  localparam int SCALE_SHIFT       = COORD_FRAC_BITS + SPACING_FRAC_BITS - KFRAC;

  // Field and datapath widths
  localparam int COORD_W   = 32;
  localparam int SPACE_W   = 32;
  localparam int PROD_W    = COORD_W + SPACE_W;
  localparam int A_W       = KFRAC + 1;          // |r| below two
  localparam int D_W       = 2 * A_W;            // radicand
  localparam int SQRT_STEPS = A_W;               // one root bit per stage
  localparam int K_W       = KFRAC + 3;          // 8*phi, at most 4.0
  localparam int WEIGHT_W  = 23;
  localparam int ROUND_SHIFT = 2 * KFRAC - KFRAC + 6; // 8*8 scale and Q0.24

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Y = CFG_IDX_W'(1);
  localparam logic [SPACE_W-1:0]   INV_SPACING_RESET = SPACE_W'(65536);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Classified item handed from front to back
  typedef struct packed {
    logic [A_W-1:0] a_x;
    logic [A_W-1:0] a_y;
    logic           in_x;
    logic           in_y;
  } ibdk_item_t;

endpackage

// File: design/ibdk_if.sv
// Interfaces: input offset channel and output weight channel.
interface ibdk_in_if;
  import ibdk_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] offset_x;
  logic signed [COORD_W-1:0] offset_y;
  modport source (output valid, output offset_x, output offset_y, input ready);
  modport sink   (input valid, input offset_x, input offset_y, output ready);
endinterface

interface ibdk_out_if;
  import ibdk_pkg::*;
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                in_support;
  modport source (output valid, output weight, output in_support, input ready);
  modport sink   (input valid, input weight, input in_support, output ready);
endinterface

// File: design/ibdk_front.sv
// Front: takes offsets, scales them by the reciprocal spacing and classifies.
module ibdk_front import ibdk_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  ibdk_in_if.sink             in_ch,
  input  logic [SPACE_W-1:0]  inv_x,
  input  logic [SPACE_W-1:0]  inv_y,
  input  logic                q_full,
  output logic                q_push,
  output ibdk_item_t          q_item
);

  logic                valid_s1;
  logic [PROD_W-1:0]   prod_x;
  logic [PROD_W-1:0]   prod_y;
  logic [COORD_W-1:0]  mag_x;
  logic [COORD_W-1:0]  mag_y;
  logic                adv;

  // Magnitude; the most negative value maps to 2^31 in 32 unsigned bits
  assign mag_x = in_ch.offset_x[COORD_W-1] ? (~in_ch.offset_x + 1'b1) : in_ch.offset_x;
  assign mag_y = in_ch.offset_y[COORD_W-1] ? (~in_ch.offset_y + 1'b1) : in_ch.offset_y;

  assign adv         = !valid_s1 || !q_full;
  assign in_ch.ready = adv;

  // Scaling multiply, one per axis
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
    end else if (adv) begin
      valid_s1 <= in_ch.valid;
    end
    if (adv) begin
      prod_x <= PROD_W'(mag_x) * PROD_W'(inv_x);
      prod_y <= PROD_W'(mag_y) * PROD_W'(inv_y);
    end
  end

  // Classify: support test and truncation to 24 fraction bits
  always_comb begin
    q_push       = valid_s1 && !q_full;
    q_item.a_x   = prod_x[SCALE_SHIFT +: A_W];
    q_item.a_y   = prod_y[SCALE_SHIFT +: A_W];
    q_item.in_x  = (prod_x[PROD_W-1:SCALE_SHIFT+A_W] == '0);
    q_item.in_y  = (prod_y[PROD_W-1:SCALE_SHIFT+A_W] == '0);
  end

endmodule

// File: design/ibdk_queue.sv
// Queue: short FIFO of classified items between front and back.
module ibdk_queue import ibdk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ibdk_item_t push_item,
  input  logic       pop,
  output ibdk_item_t head,
  output logic       empty,
  output logic       full
);

  ibdk_item_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

endmodule

// File: design/ibdk_sqrt.sv
// Pipelined integer square root, one root bit per stage, rounded down.
module ibdk_sqrt import ibdk_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [D_W-1:0] radicand,
  output logic [A_W-1:0] root
);

  logic [D_W-1:0] rem_q [SQRT_STEPS];
  logic [D_W-1:0] res_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [D_W-1:0] BIT = D_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [D_W-1:0] rem_in;
    logic [D_W-1:0] res_in;
    logic [D_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};

    // Restoring step: subtract when the trial fits
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[k] <= rem_in - trial[D_W-1:0];
          res_q[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_q[SQRT_STEPS-1][A_W-1:0];

endmodule

// File: design/ibdk_back.sv
// Back: kernel branches per axis, root extraction, product and rounding.
module ibdk_back import ibdk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ibdk_item_t head,
  input  logic       q_empty,
  output logic       q_pop,
  ibdk_out_if.source out_ch
);

  localparam logic [K_W+2:0] ONE = (K_W+3)'(1) << KFRAC;

  typedef struct packed {
    logic           valid;
    logic [A_W-1:0] a_x;
    logic [A_W-1:0] a_y;
    logic           in_x;
    logic           in_y;
  } side_t;

  logic               adv;
  side_t              s0;
  side_t              s1;
  side_t              sq [SQRT_STEPS];
  logic [D_W-1:0]     aa_x;
  logic [D_W-1:0]     aa_y;
  logic [D_W-1:0]     d_x;
  logic [D_W-1:0]     d_y;
  logic [A_W-1:0]     root_x;
  logic [A_W-1:0]     root_y;
  logic [K_W-1:0]     kx;
  logic [K_W-1:0]     ky;
  logic               v2;
  logic               sup2;
  logic [2*K_W-1:0]   prod;
  logic               v3;
  logic               sup3;

  assign adv   = !out_ch.valid || out_ch.ready;
  assign q_pop = adv;

  // Radicand of either branch, exact with 48 fraction bits
  function automatic logic [D_W-1:0] radicand(input logic [A_W-1:0] a,
                                               input logic [D_W-1:0] aa);
    logic [D_W+1:0] r;
    if (!a[A_W-1]) begin
      r = ((D_W+2)'(1) << (2 * KFRAC)) + ((D_W+2)'(a) << (KFRAC + 2))
          - ((D_W+2)'(aa) << 2);
    end else begin
      r = (((D_W+2)'(a) * (D_W+2)'(12)) << KFRAC) - ((D_W+2)'(aa) << 2)
          - ((D_W+2)'(7) << (2 * KFRAC));
    end
    return r[D_W-1:0];
  endfunction

  // 8*phi from branch, offset and root, clamped at zero
  function automatic logic [K_W-1:0] kernel(input logic [A_W-1:0] a,
                                            input logic [A_W-1:0] s);
    logic signed [K_W+2:0] n;
    if (!a[A_W-1]) begin
      n = $signed(ONE * (K_W+3)'(3)) - $signed((K_W+3)'(a) << 1) + $signed((K_W+3)'(s));
    end else begin
      n = $signed(ONE * (K_W+3)'(5)) - $signed((K_W+3)'(a) << 1) - $signed((K_W+3)'(s));
    end
    return n[K_W+2] ? '0 : n[K_W-1:0];
  endfunction

  // Take from queue, square the offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
      s1.valid <= 1'b0;
    end else if (adv) begin
      s0.valid <= !q_empty;
      s1.valid <= s0.valid;
    end
    if (adv) begin
      s0.a_x  <= head.a_x;
      s0.a_y  <= head.a_y;
      s0.in_x <= head.in_x;
      s0.in_y <= head.in_y;
      aa_x    <= D_W'(s0.a_x) * D_W'(s0.a_x);
      aa_y    <= D_W'(s0.a_y) * D_W'(s0.a_y);
      s1.a_x  <= s0.a_x;
      s1.a_y  <= s0.a_y;
      s1.in_x <= s0.in_x;
      s1.in_y <= s0.in_y;
    end
  end

  // Radicand register and the root pipelines
  always_ff @(posedge clk) begin
    if (adv) begin
      d_x <= radicand(s1.a_x, aa_x);
      d_y <= radicand(s1.a_y, aa_y);
    end
  end

  ibdk_sqrt u_sqrt_x (.clk(clk), .en(adv), .radicand(d_x), .root(root_x));
  ibdk_sqrt u_sqrt_y (.clk(clk), .en(adv), .radicand(d_y), .root(root_y));

  // Side data delayed alongside the radicand and root stages
  side_t sq_in;
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_in.valid <= 1'b0;
      for (int i = 0; i < SQRT_STEPS; i++) sq[i].valid <= 1'b0;
    end else if (adv) begin
      sq_in.valid <= s1.valid;
      sq[0].valid <= sq_in.valid;
      for (int i = 1; i < SQRT_STEPS; i++) sq[i].valid <= sq[i-1].valid;
    end
    if (adv) begin
      sq_in.a_x  <= s1.a_x;
      sq_in.a_y  <= s1.a_y;
      sq_in.in_x <= s1.in_x;
      sq_in.in_y <= s1.in_y;
      sq[0].a_x  <= sq_in.a_x;
      sq[0].a_y  <= sq_in.a_y;
      sq[0].in_x <= sq_in.in_x;
      sq[0].in_y <= sq_in.in_y;
      for (int i = 1; i < SQRT_STEPS; i++) begin
        sq[i].a_x  <= sq[i-1].a_x;
        sq[i].a_y  <= sq[i-1].a_y;
        sq[i].in_x <= sq[i-1].in_x;
        sq[i].in_y <= sq[i-1].in_y;
      end
    end
  end

  // Axis kernels, product, rounding to Q0.24
  always_ff @(posedge clk) begin
    if (rst) begin
      v2           <= 1'b0;
      v3           <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      v2           <= sq[SQRT_STEPS-1].valid;
      v3           <= v2;
      out_ch.valid <= v3;
    end
    if (adv) begin
      kx   <= kernel(sq[SQRT_STEPS-1].a_x, root_x);
      ky   <= kernel(sq[SQRT_STEPS-1].a_y, root_y);
      sup2 <= sq[SQRT_STEPS-1].in_x && sq[SQRT_STEPS-1].in_y;
      prod <= (2*K_W)'(kx) * (2*K_W)'(ky);
      sup3 <= sup2;
      out_ch.in_support <= sup3;
      out_ch.weight <= sup3 ?
        WEIGHT_W'((prod + ((2*K_W)'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT) : '0;
    end
  end

endmodule

// File: design/immersed_boundary_delta_kernel.sv
// Top level: four-point regularized delta weight for one 2-D offset.
// Takes one offset pair per cycle while the queue has room and returns one
// weight per item, in order. The path runs through the front scaling multiply
// register, classification into the queue, the queue, the take, square and
// radicand stages, 25 root stages (one root bit each), then the kernel,
// product and rounding registers. Throughput is one item per cycle;
// a stalled output stops the back pipeline and the four-entry queue lets the
// front keep taking items until it fills. Configuration writes to the
// reciprocal spacings apply to items accepted afterwards.
module immersed_boundary_delta_kernel import ibdk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPACE_W-1:0]   cfg_data,
  ibdk_in_if.sink              in_ch,
  ibdk_out_if.source           out_ch
);

  logic [SPACE_W-1:0] inv_spacing_x;
  logic [SPACE_W-1:0] inv_spacing_y;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic               q_full;
  ibdk_item_t         q_in;
  ibdk_item_t         q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spacing_x <= INV_SPACING_RESET;
      inv_spacing_y <= INV_SPACING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_SPACING_X: inv_spacing_x <= cfg_data;
        REG_INV_SPACING_Y: inv_spacing_y <= cfg_data;
        default: ;
      endcase
    end
  end

  ibdk_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .inv_x(inv_spacing_x), .inv_y(inv_spacing_y),
    .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  ibdk_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(q_in),
    .pop(q_pop), .head(q_head), .empty(q_empty), .full(q_full)
  );

  ibdk_back u_back (
    .clk(clk), .rst(rst), .head(q_head), .q_empty(q_empty),
    .q_pop(q_pop), .out_ch(out_ch)
  );

endmodule
